// ===== hdl/bbia_pkg.sv =====
// Shared types and codes for the block and inode bitmap allocator.
// No dependencies; imported by every module in hdl/.
`timescale 1ns / 1ps
`default_nettype none

package bbia_pkg;

    // Bitmap rows are 32 bits wide
    localparam int WORD_W  = 32;
    localparam int WORD_AW = 5;

    typedef enum logic [2:0] {
        OP_FIND_BLOCK  = 3'd0,
        OP_SET_BLOCK   = 3'd1,
        OP_CLEAR_BLOCK = 3'd2,
        OP_FIND_INODE  = 3'd3,
        OP_SET_INODE   = 3'd4,
        OP_CLEAR_INODE = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_READ  = 2'd1,
        S_CHECK = 2'd2
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/bbia_map_ram.sv =====
// One bitmap memory: 32-bit rows, one read and one write port, registered read.
// Rows never written since reset read as all free. Depends on bbia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbia_map_ram #(
    parameter int DEPTH = 4,
    parameter int AW    = 2
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_rd_en,
    input  wire logic [AW-1:0]              i_rd_addr,
    output logic      [bbia_pkg::WORD_W-1:0] o_rd_data,
    input  wire logic                       i_wr_en,
    input  wire logic [AW-1:0]              i_wr_addr,
    input  wire logic [bbia_pkg::WORD_W-1:0] i_wr_data
);
    import bbia_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_row_valid;
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_row_valid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    // Drop all rows back to free on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (i_wr_en) begin
            r_row_valid[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/bitmap_block_inode_allocator_core.sv =====
// Block and inode bitmap allocator: find, set and clear on two bitmaps.
// A set or clear passes through S_READ and S_CHECK before o_valid; a search repeats
// them for each row scanned (32 entries per row) until a free entry or the last row.
// busy is low again in the o_valid cycle, so a new beat may start then.
// Reset (synchronous, active low) frees every entry at once; no clearing pass.
// Depends on bbia_pkg and bbia_map_ram.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_inode_allocator_core #(
    parameter int BLOCK_COUNT = 128,
    parameter int INODE_COUNT = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] i_opcode,
    input  wire logic [7:0] i_item_number,
    input  wire logic       i_cfg_we,
    input  wire logic [4:0] i_cfg_first_unreserved_inode,
    output logic            o_valid,
    output logic [1:0]      o_status,
    output logic [7:0]      o_found_number,
    output logic [7:0]      o_free_blocks
);
    import bbia_pkg::*;

    localparam int BROWS = (BLOCK_COUNT + WORD_W - 1) / WORD_W;
    localparam int IROWS = (INODE_COUNT + WORD_W - 1) / WORD_W;
    localparam int BAW   = (BROWS > 1) ? $clog2(BROWS) : 1;
    localparam int IAW   = (IROWS > 1) ? $clog2(IROWS) : 1;
    localparam int RAW   = (BAW > IAW) ? BAW : IAW;
    localparam int GW    = RAW + WORD_AW;
    localparam int FCW   = $clog2(BLOCK_COUNT + 1);

    localparam logic [RAW-1:0] BLK_LAST = RAW'(BROWS - 1);
    localparam logic [RAW-1:0] INO_LAST = RAW'(IROWS - 1);
    localparam logic [GW:0]    BLK_LIM  = (GW + 1)'(BLOCK_COUNT);
    localparam logic [GW:0]    INO_LIM  = (GW + 1)'(INODE_COUNT);
    localparam logic [10:0]    BLK_NUM_MAX = 11'(BLOCK_COUNT);
    localparam logic [10:0]    INO_NUM_MAX = 11'(INODE_COUNT);

    t_state               r_state, n_state;
    t_opcode              r_op, n_op;
    logic                 r_bad, n_bad;
    logic [RAW-1:0]       r_row, n_row;
    logic [WORD_AW-1:0]   r_bit, n_bit;
    logic [4:0]           r_first;
    logic [FCW-1:0]       r_free, n_free;
    logic                 r_valid, n_valid;
    t_status              r_status, n_status;
    logic [7:0]           r_found, n_found;

    logic [WORD_W-1:0]    blk_rdata, ino_rdata, word, free_vec, mask, new_word;
    logic                 is_inode, blk_wr, ino_wr, any_free;
    logic [WORD_AW-1:0]   pos;
    logic [GW-1:0]        g_idx;
    logic [GW:0]          g_bit;
    logic [7:0]           num_m1;
    logic [10:0]          num_ext;

    assign is_inode = (r_op == OP_FIND_INODE) || (r_op == OP_SET_INODE)
                   || (r_op == OP_CLEAR_INODE);
    assign word     = is_inode ? ino_rdata : blk_rdata;
    assign num_m1   = i_item_number - 8'd1;
    assign num_ext  = {3'b000, i_item_number};

    // Search window within the current row
    always_comb begin
        mask = '0;
        for (int b = 0; b < WORD_W; b++) begin
            g_bit = {1'b0, r_row, WORD_AW'(b)};
            if (is_inode) begin
                mask[b] = (g_bit < INO_LIM) && (g_bit >= (GW + 1)'(r_first));
            end else begin
                mask[b] = (g_bit < BLK_LIM);
            end
        end
    end

    assign free_vec = ~word & mask;
    assign any_free = |free_vec;

    // Lowest free bit wins
    always_comb begin
        pos = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (free_vec[b]) begin
                pos = WORD_AW'(b);
            end
        end
    end

    assign g_idx = {r_row, pos};

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_bad    = r_bad;
        n_row    = r_row;
        n_bit    = r_bit;
        n_free   = r_free;
        n_valid  = 1'b0;
        n_status = r_status;
        n_found  = r_found;
        blk_wr   = 1'b0;
        ino_wr   = 1'b0;
        new_word = word;
        new_word[r_bit] = (r_op == OP_SET_BLOCK) || (r_op == OP_SET_INODE);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op  = t_opcode'(i_opcode);
                    n_bit = num_m1[WORD_AW-1:0];
                    n_row = '0;
                    case (t_opcode'(i_opcode))
                        OP_FIND_BLOCK, OP_FIND_INODE: begin
                            n_bad = 1'b0;
                        end
                        OP_SET_BLOCK, OP_CLEAR_BLOCK: begin
                            n_bad = (i_item_number == 8'd0) || (num_ext > BLK_NUM_MAX);
                            n_row = RAW'(num_m1[7:WORD_AW]);
                        end
                        OP_SET_INODE, OP_CLEAR_INODE: begin
                            n_bad = (i_item_number == 8'd0) || (num_ext > INO_NUM_MAX);
                            n_row = RAW'(num_m1[7:WORD_AW]);
                        end
                        default: begin
                            n_bad = 1'b1;
                        end
                    endcase
                    if (n_bad) begin
                        n_row = '0;
                    end
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
                n_found = '0;
                if (r_bad) begin
                    n_status = ST_BAD;
                end else begin
                    case (r_op)
                        OP_FIND_BLOCK, OP_FIND_INODE: begin
                            if (any_free) begin
                                n_status = ST_OK;
                                n_found  = 8'({1'b0, g_idx} + (GW + 1)'(1));
                            end else if (r_row == (is_inode ? INO_LAST : BLK_LAST)) begin
                                n_status = ST_NONE;
                            end else begin
                                // Advance to the next row and keep scanning
                                n_valid = 1'b0;
                                n_row   = r_row + RAW'(1);
                                n_state = S_READ;
                            end
                        end
                        OP_SET_BLOCK: begin
                            n_status = ST_OK;
                            blk_wr   = 1'b1;
                            if (!word[r_bit]) begin
                                n_free = r_free - FCW'(1);
                            end
                        end
                        OP_CLEAR_BLOCK: begin
                            n_status = ST_OK;
                            blk_wr   = 1'b1;
                            if (word[r_bit]) begin
                                n_free = r_free + FCW'(1);
                            end
                        end
                        OP_SET_INODE, OP_CLEAR_INODE: begin
                            n_status = ST_OK;
                            ino_wr   = 1'b1;
                        end
                        default: begin
                            n_status = ST_BAD;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_free  <= FCW'(BLOCK_COUNT);
            r_first <= 5'd11;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_free  <= n_free;
            if (i_cfg_we) begin
                r_first <= i_cfg_first_unreserved_inode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_bad    <= n_bad;
        r_row    <= n_row;
        r_bit    <= n_bit;
        r_status <= n_status;
        r_found  <= n_found;
    end

    bbia_map_ram #(
        .DEPTH (BROWS),
        .AW    (BAW)
    ) u_block_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   ((r_state == S_READ) && !is_inode),
        .i_rd_addr (r_row[BAW-1:0]),
        .o_rd_data (blk_rdata),
        .i_wr_en   (blk_wr),
        .i_wr_addr (r_row[BAW-1:0]),
        .i_wr_data (new_word)
    );

    bbia_map_ram #(
        .DEPTH (IROWS),
        .AW    (IAW)
    ) u_inode_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   ((r_state == S_READ) && is_inode),
        .i_rd_addr (r_row[IAW-1:0]),
        .o_rd_data (ino_rdata),
        .i_wr_en   (ino_wr),
        .i_wr_addr (r_row[IAW-1:0]),
        .i_wr_data (new_word)
    );

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_found_number = r_found;
    assign o_free_blocks  = 8'(r_free);

`ifndef SYNTHESIS
    a_result_follows_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_CHECK))
        else $error("result beat without a check cycle");

    a_free_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= FCW'(BLOCK_COUNT))
        else $error("free block count above block count");

    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted beat did not raise busy");

    a_no_found_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_found_number == 8'd0))
        else $error("found number on a failed beat");
`endif

endmodule

`default_nettype wire

// ===== test/bitmap_block_inode_allocator_core_tb.sv =====
// Self-checking testbench for bitmap_block_inode_allocator_core.
// A scoreboard class tracks both bitmaps and predicts each result; plain tasks drive beats.
// Depends on bbia_pkg and the allocator RTL in hdl/.
`timescale 1ns / 1ps

module bitmap_block_inode_allocator_core_tb;
    import bbia_pkg::*;

    localparam int BLOCKS = 128;
    localparam int INODES = 32;
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;
    localparam int BEAT_TARGET = 1750;

    typedef struct {
        t_status    status;
        logic [7:0] found_number;
        logic [7:0] free_blocks;
    } t_alloc_result;

    class t_alloc_scoreboard;
        bit            block_used [BLOCKS];
        bit            inode_used [INODES];
        logic [4:0]    first_inode;
        t_alloc_result pending_results [$];
        int            errors;
        int            checked;
        int            beats;

        function new();
            foreach (block_used[i]) block_used[i] = 1'b0;
            foreach (inode_used[i]) inode_used[i] = 1'b0;
            first_inode = 5'd11;
            errors      = 0;
            checked     = 0;
            beats       = 0;
        endfunction

        function int lowest_free_block();
            for (int i = 0; i < BLOCKS; i++) begin
                if (!block_used[i]) return i + 1;
            end
            return 0;
        endfunction

        function int lowest_free_inode();
            for (int i = int'(first_inode); i < INODES; i++) begin
                if (!inode_used[i]) return i + 1;
            end
            return 0;
        endfunction

        // Apply one accepted beat to the maps and queue the result it must produce
        function void note_beat(logic [2:0] op, logic [7:0] num);
            t_alloc_result r;
            int            free_count;
            r.status       = ST_OK;
            r.found_number = 8'd0;
            case (op)
                OP_FIND_BLOCK: begin
                    r.found_number = 8'(lowest_free_block());
                    if (r.found_number == 8'd0) r.status = ST_NONE;
                end
                OP_SET_BLOCK, OP_CLEAR_BLOCK: begin
                    if (num == 8'd0 || int'(num) > BLOCKS) r.status = ST_BAD;
                    else block_used[num - 1] = (op == OP_SET_BLOCK);
                end
                OP_FIND_INODE: begin
                    r.found_number = 8'(lowest_free_inode());
                    if (r.found_number == 8'd0) r.status = ST_NONE;
                end
                OP_SET_INODE, OP_CLEAR_INODE: begin
                    if (num == 8'd0 || int'(num) > INODES) r.status = ST_BAD;
                    else inode_used[num - 1] = (op == OP_SET_INODE);
                end
                default: r.status = ST_BAD;
            endcase
            free_count = 0;
            foreach (block_used[i]) if (!block_used[i]) free_count++;
            r.free_blocks = free_count[7:0];
            pending_results.push_back(r);
            beats++;
        endfunction

        function void check_result(logic [1:0] st, logic [7:0] fnd, logic [7:0] fb);
            t_alloc_result e;
            if (pending_results.size() == 0) begin
                $error("result with no beat outstanding: status %0d found %0d free %0d",
                       st, fnd, fb);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            checked++;
            if (st !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (fnd !== e.found_number) begin
                $error("found_number: expected %0d, got %0d", e.found_number, fnd);
                errors++;
            end
            if (fb !== e.free_blocks) begin
                $error("free_blocks: expected %0d, got %0d", e.free_blocks, fb);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [2:0] i_opcode = OP_FIND_BLOCK;
    logic [7:0] i_item_number = 8'd0;
    logic       i_cfg_we = 1'b0;
    logic [4:0] i_cfg_first_unreserved_inode = 5'd0;
    logic       o_valid;
    logic [1:0] o_status;
    logic [7:0] o_found_number;
    logic [7:0] o_free_blocks;

    t_alloc_scoreboard sb = new();
    int  cfg_writes = 0;
    int  full_block_hits = 0;
    bit  no_idle = 1'b0;

    bitmap_block_inode_allocator_core #(
        .BLOCK_COUNT(BLOCKS),
        .INODE_COUNT(INODES)
    ) uut (
        .i_clk                        (i_clk),
        .i_rst_n                      (i_rst_n),
        .start                        (start),
        .busy                         (busy),
        .i_opcode                     (i_opcode),
        .i_item_number                (i_item_number),
        .i_cfg_we                     (i_cfg_we),
        .i_cfg_first_unreserved_inode (i_cfg_first_unreserved_inode),
        .o_valid                      (o_valid),
        .o_status                     (o_status),
        .o_found_number               (o_found_number),
        .o_free_blocks                (o_free_blocks)
    );

    always #5 i_clk = ~i_clk;

    // Sample everything at the rising edge, before the block's registers move
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) sb.check_result(o_status, o_found_number, o_free_blocks);
            if (i_cfg_we) sb.first_inode = i_cfg_first_unreserved_inode;
            if (start && !busy) begin
                if (i_opcode == OP_FIND_BLOCK && sb.lowest_free_block() == 0)
                    full_block_hits++;
                sb.note_beat(i_opcode, i_item_number);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [2:0] op, input logic [7:0] num);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start         = 1'b1;
        i_opcode      = op;
        i_item_number = num;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic write_first_inode(input logic [4:0] value);
        start = 1'b0;
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        i_cfg_we                     = 1'b1;
        i_cfg_first_unreserved_inode = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        cfg_writes++;
    endtask

    // Mostly in range, with zero and arbitrary bytes mixed in
    function automatic logic [7:0] rand_number(input int size);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 8'd0;
        if (pick == 1) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(1, size));
    endfunction

    // Search then claim the lowest free entry, as a file system would
    task automatic allocate_pair(input bit inode_side);
        int n;
        if (inode_side) begin
            send_beat(OP_FIND_INODE, 8'($urandom_range(0, 255)));
            n = sb.lowest_free_inode();
            send_beat(OP_SET_INODE, (n == 0) ? rand_number(INODES) : 8'(n));
        end else begin
            send_beat(OP_FIND_BLOCK, 8'($urandom_range(0, 255)));
            n = sb.lowest_free_block();
            send_beat(OP_SET_BLOCK, (n == 0) ? rand_number(BLOCKS) : 8'(n));
        end
    endtask

    task automatic random_beat();
        logic [2:0] op;
        if ($urandom_range(0, 19) == 0)
            op = 3'($urandom_range(int'(OP_UNUSED_6), int'(OP_UNUSED_7)));
        else
            op = 3'($urandom_range(int'(OP_FIND_BLOCK), int'(OP_CLEAR_INODE)));
        if (op == OP_SET_INODE || op == OP_CLEAR_INODE) send_beat(op, rand_number(INODES));
        else send_beat(op, rand_number(BLOCKS));
    endtask

    initial begin
        int         phase;
        int         mode;
        int         drain_pick;
        logic [4:0] cfg_value;

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: range edges, bad numbers, unused opcodes, inode search window
        send_beat(OP_FIND_BLOCK, 8'hFF);
        send_beat(OP_SET_BLOCK, 8'd1);
        send_beat(OP_SET_BLOCK, 8'd128);
        send_beat(OP_SET_BLOCK, 8'd0);
        send_beat(OP_SET_BLOCK, 8'd129);
        send_beat(OP_CLEAR_BLOCK, 8'd255);
        send_beat(OP_FIND_BLOCK, 8'd0);
        send_beat(OP_CLEAR_BLOCK, 8'd1);
        send_beat(OP_CLEAR_BLOCK, 8'd128);
        send_beat(OP_FIND_INODE, 8'd0);
        send_beat(OP_SET_INODE, 8'd12);
        send_beat(OP_FIND_INODE, 8'd77);
        send_beat(OP_SET_INODE, 8'd32);
        send_beat(OP_SET_INODE, 8'd33);
        send_beat(OP_CLEAR_INODE, 8'd0);
        send_beat(OP_UNUSED_6, 8'd5);
        send_beat(OP_UNUSED_7, 8'd0);
        write_first_inode(5'd31);
        send_beat(OP_FIND_INODE, 8'd0);
        send_beat(OP_CLEAR_INODE, 8'd32);
        send_beat(OP_FIND_INODE, 8'd0);
        write_first_inode(5'd0);
        send_beat(OP_SET_INODE, 8'd1);
        send_beat(OP_FIND_INODE, 8'd0);

        // Random phases: fill, mixed, drain; a new search window before each
        phase = 0;
        while (sb.beats < BEAT_TARGET) begin
            case (phase)
                0:       cfg_value = 5'd0;
                1:       cfg_value = 5'd31;
                2:       cfg_value = 5'd11;
                default: cfg_value = 5'($urandom_range(0, 31));
            endcase
            write_first_inode(cfg_value);
            no_idle = ($urandom_range(0, 3) == 0);
            mode    = phase % 3;
            repeat (120) begin
                case (mode)
                    0: begin
                        if ($urandom_range(0, 9) < 7) allocate_pair($urandom_range(0, 3) == 0);
                        else random_beat();
                    end
                    1: random_beat();
                    default: begin
                        drain_pick = $urandom_range(0, 9);
                        if (drain_pick < 5) send_beat(OP_CLEAR_BLOCK, rand_number(BLOCKS));
                        else if (drain_pick < 8) send_beat(OP_CLEAR_INODE, rand_number(INODES));
                        else random_beat();
                    end
                endcase
            end
            phase++;
        end
        start = 1'b0;

        for (int w = 0; w < 1000 && sb.pending_results.size() != 0; w++) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.pending_results.size() != 0) begin
            $error("%0d results never arrived", sb.pending_results.size());
            sb.errors++;
        end

        $display("Checked %0d results from %0d beats across %0d search-window settings",
                 sb.checked, sb.beats, cfg_writes);
        $display("Block searches with the block map full: %0d", full_block_hits);
        if (sb.errors == 0) begin
            $display("** bitmap_block_inode_allocator_core: PASSED **");
        end else begin
            $display("** bitmap_block_inode_allocator_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout waiting on the block");
        $display("** bitmap_block_inode_allocator_core: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/bbia_pkg.sv
hdl/bbia_map_ram.sv
hdl/bitmap_block_inode_allocator_core.sv
test/bitmap_block_inode_allocator_core_tb.sv
